/* rtl/vtnc_pkg.sv */
package vtnc_pkg;

  localparam int CFG_NUM   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam logic signed [31:0] Q_ONE   = 32'sd65536;
  localparam logic signed [31:0] Q_NEAR  = 32'sd6554;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // divider: input register, one stage per quotient bit, output register
  localparam int DIV_QBITS = 32;
  localparam int DIV_LAT   = DIV_QBITS + 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef logic [CFG_NUM-1:0][CFG_W-1:0] cfg_regs_t;

  // identity matrix
  localparam cfg_regs_t CFG_RESET = {
    64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  // transformed vertex handed from front to back
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] win;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] cw;
    logic               clipped;
    logic               fault;
  } clip_item_t;

  // {saturated flag, value}
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) begin
      r = {1'b1, S32_MAX};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, S32_MIN};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

/* rtl/vtnc_if.sv */
interface vtnc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] pos_w;
  modport source (output valid, pos_x, pos_y, pos_z, pos_w, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, pos_w, output ready);
endinterface

interface vtnc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] screen_z;
  logic signed [31:0] inv_w;
  logic               near_clipped;
  logic               range_fault;
  modport source (output valid, screen_x, screen_y, screen_z, inv_w, near_clipped,
                  range_fault, input ready);
  modport sink (input valid, screen_x, screen_y, screen_z, inv_w, near_clipped,
                range_fault, output ready);
endinterface

/* rtl/vtnc_div.sv */
// Signed (a * 2^16) / d, truncated, saturated to 32 bits. One quotient bit per stage.
module vtnc_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] d_i,
  output logic signed [31:0] q_o,
  output logic               fault_o
);
  import vtnc_pkg::*;

  logic [32:0] ma, md;
  logic        neg, zero, ovf;
  logic [48:0] adiv;
  logic [64:0] lim_md;

  logic [32:0]          r_q    [DIV_QBITS+1];
  logic [DIV_QBITS-1:0] aq_q   [DIV_QBITS+1];
  logic [32:0]          md_q   [DIV_QBITS+1];
  logic                 neg_q  [DIV_QBITS+1];
  logic                 spec_q [DIV_QBITS+1];
  logic                 smin_q [DIV_QBITS+1];

  logic [32:0]          r_nx  [DIV_QBITS];
  logic [DIV_QBITS-1:0] aq_nx [DIV_QBITS];
  logic [33:0]          trial [DIV_QBITS];

  logic signed [31:0] q_q;
  logic               flt_q;
  logic [DIV_QBITS-1:0] qm;

  always_comb begin
    ma     = a_i[32] ? 33'(-a_i) : 33'(a_i);
    md     = d_i[32] ? 33'(-d_i) : 33'(d_i);
    neg    = a_i[32] ^ d_i[32];
    adiv   = {ma, 16'b0};
    zero   = (md == 33'd0);
    // quotient too big when a*2^16 >= md * (2^31, or 2^31+1 for a negative result)
    lim_md = 65'({md, 31'b0}) + 65'(neg ? md : 33'd0);
    ovf    = !zero && (65'(adiv) >= lim_md);
  end

  always_comb begin
    for (int k = 0; k < DIV_QBITS; k++) begin
      trial[k] = {r_q[k], aq_q[k][DIV_QBITS-1]};
      if (trial[k] >= 34'(md_q[k])) begin
        r_nx[k]  = 33'(trial[k] - 34'(md_q[k]));
        aq_nx[k] = {aq_q[k][DIV_QBITS-2:0], 1'b1};
      end else begin
        r_nx[k]  = trial[k][32:0];
        aq_nx[k] = {aq_q[k][DIV_QBITS-2:0], 1'b0};
      end
    end
  end

  assign qm = aq_q[DIV_QBITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= 33'(adiv[48:32]);
      aq_q[0]   <= adiv[31:0];
      md_q[0]   <= md;
      neg_q[0]  <= neg;
      spec_q[0] <= zero || ovf;
      smin_q[0] <= zero ? a_i[32] : neg;
      for (int k = 0; k < DIV_QBITS; k++) begin
        r_q[k+1]    <= r_nx[k];
        aq_q[k+1]   <= aq_nx[k];
        md_q[k+1]   <= md_q[k];
        neg_q[k+1]  <= neg_q[k];
        spec_q[k+1] <= spec_q[k];
        smin_q[k+1] <= smin_q[k];
      end
      if (spec_q[DIV_QBITS]) begin
        q_q <= smin_q[DIV_QBITS] ? S32_MIN : S32_MAX;
      end else begin
        q_q <= neg_q[DIV_QBITS] ? -$signed(qm) : $signed(qm);
      end
      flt_q <= spec_q[DIV_QBITS];
    end
  end

  assign q_o     = q_q;
  assign fault_o = flt_q;

endmodule

/* rtl/vtnc_fifo.sv */
module vtnc_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  vtnc_pkg::clip_item_t   data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output vtnc_pkg::clip_item_t   data_o,
  output logic                   empty_o
);
  import vtnc_pkg::*;

  clip_item_t            mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue pushed while full");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue popped while empty");

endmodule

/* rtl/vtnc_front.sv */
// Matrix transform: products, then sum/floor/saturate, classify clip w.
module vtnc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  vtnc_in_if.sink              vtx_i,
  input  vtnc_pkg::cfg_regs_t  cfg_i,
  input  logic                 full_i,
  output logic                 push_o,
  output vtnc_pkg::clip_item_t item_o
);
  import vtnc_pkg::*;

  logic signed [31:0] coef  [4][4];   // [row][col]
  logic signed [31:0] pos   [3];
  logic signed [63:0] prod_q [4][3];  // [col][row]
  logic signed [31:0] vx_q, vy_q, win_q;
  logic               vld1_q, vld2_q, en;
  logic signed [65:0] sum   [4];
  logic [32:0]        sat   [4];
  clip_item_t         item_q;

  assign pos[0] = vtx_i.pos_x;
  assign pos[1] = vtx_i.pos_y;
  assign pos[2] = vtx_i.pos_z;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = (c % 2 == 1) ? cfg_i[r*2 + c/2][63:32] : cfg_i[r*2 + c/2][31:0];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = (66'(coef[3][c]) <<< 16) + 66'(prod_q[c][0]) + 66'(prod_q[c][1])
             + 66'(prod_q[c][2]);
      sat[c] = sat32(sum[c] >>> 16);
    end
  end

  assign en          = !(vld2_q && full_i);
  assign vtx_i.ready = en;
  assign push_o      = vld2_q && !full_i;
  assign item_o      = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en) begin
      vld1_q <= vtx_i.valid;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_q[c][r] <= 64'(coef[r][c]) * 64'(pos[r]);
        end
      end
      vx_q  <= vtx_i.pos_x;
      vy_q  <= vtx_i.pos_y;
      win_q <= vtx_i.pos_w;
      item_q.vx      <= vx_q;
      item_q.vy      <= vy_q;
      item_q.win     <= win_q;
      item_q.cx      <= sat[0][31:0];
      item_q.cy      <= sat[1][31:0];
      item_q.cz      <= sat[2][31:0];
      item_q.cw      <= sat[3][31:0];
      item_q.clipped <= sat[3][31];
      item_q.fault   <= sat[0][32] | sat[1][32] | sat[2][32] | sat[3][32];
    end
  end

endmodule

/* rtl/vtnc_back.sv */
// Near factor divide, interpolation, four perspective divides, output register.
module vtnc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vtnc_pkg::clip_item_t data_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  vtnc_out_if.source           res_o
);
  import vtnc_pkg::*;

  localparam int BACK_LAT = 2*DIV_LAT + 3;

  logic [BACK_LAT-1:0] vld_q;
  logic                en;

  logic signed [32:0] num, den;
  logic signed [31:0] t;
  logic               tflt;
  clip_item_t         dly_q [DIV_LAT];
  clip_item_t         it;

  // interpolation
  logic signed [32:0] dx, dy;
  logic signed [64:0] px_q, py_q;
  clip_item_t         m1_q;
  logic               tflt_q;
  logic [32:0]        satx, saty;

  logic signed [31:0] xs_q, ys_q, zs_q, ws_q;
  logic               clp2_q, flt2_q;
  logic [1:0]         fl_q [DIV_LAT];

  logic signed [31:0] qx, qy, qz, qw;
  logic               fx, fy, fz, fw;

  logic signed [31:0] ox_q, oy_q, oz_q, ow_q;
  logic               onear_q, oflt_q;

  assign en    = !vld_q[BACK_LAT-1] || res_o.ready;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[BACK_LAT-2:0], pop_o};
    end
  end

  assign num = 33'(Q_NEAR) - 33'(data_i.win);
  assign den = 33'(data_i.cw) - 33'(data_i.win);

  vtnc_div u_div_t (.clk_i, .en_i(en), .a_i(num), .d_i(den), .q_o(t), .fault_o(tflt));

  assign it = dly_q[DIV_LAT-1];
  assign dx = 33'(it.cx) - 33'(it.vx);
  assign dy = 33'(it.cy) - 33'(it.vy);

  assign satx = sat32(66'(m1_q.vx) + 66'(px_q >>> 16));
  assign saty = sat32(66'(m1_q.vy) + 66'(py_q >>> 16));

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= data_i;
      for (int k = 1; k < DIV_LAT; k++) dly_q[k] <= dly_q[k-1];

      px_q   <= 65'(t) * 65'(dx);
      py_q   <= 65'(t) * 65'(dy);
      m1_q   <= it;
      tflt_q <= tflt;

      xs_q   <= m1_q.clipped ? satx[31:0] : m1_q.cx;
      ys_q   <= m1_q.clipped ? saty[31:0] : m1_q.cy;
      zs_q   <= m1_q.clipped ? Q_NEAR : m1_q.cz;
      ws_q   <= m1_q.clipped ? Q_NEAR : m1_q.cw;
      clp2_q <= m1_q.clipped;
      flt2_q <= m1_q.fault | (m1_q.clipped & (tflt_q | satx[32] | saty[32]));

      fl_q[0] <= {clp2_q, flt2_q};
      for (int k = 1; k < DIV_LAT; k++) fl_q[k] <= fl_q[k-1];

      ox_q    <= qx;
      oy_q    <= qy;
      oz_q    <= qz;
      ow_q    <= qw;
      onear_q <= fl_q[DIV_LAT-1][1];
      oflt_q  <= fl_q[DIV_LAT-1][0] | fx | fy | fz | fw;
    end
  end

  vtnc_div u_div_x (.clk_i, .en_i(en), .a_i(33'(xs_q)), .d_i(33'(ws_q)), .q_o(qx),
                    .fault_o(fx));
  vtnc_div u_div_y (.clk_i, .en_i(en), .a_i(33'(ys_q)), .d_i(33'(ws_q)), .q_o(qy),
                    .fault_o(fy));
  vtnc_div u_div_z (.clk_i, .en_i(en), .a_i(33'(zs_q)), .d_i(33'(ws_q)), .q_o(qz),
                    .fault_o(fz));
  vtnc_div u_div_w (.clk_i, .en_i(en), .a_i(33'(Q_ONE)), .d_i(33'(ws_q)), .q_o(qw),
                    .fault_o(fw));

  assign res_o.valid        = vld_q[BACK_LAT-1];
  assign res_o.screen_x     = ox_q;
  assign res_o.screen_y     = oy_q;
  assign res_o.screen_z     = oz_q;
  assign res_o.inv_w        = ow_q;
  assign res_o.near_clipped = onear_q;
  assign res_o.range_fault  = oflt_q;

endmodule

/* rtl/vertex_transform_near_clip.sv */
//  channel   dir  handshake          payload
//  vtx_i     in   valid/ready        pos_x, pos_y, pos_z, pos_w (Q16.16)
//  res_o     out  valid/ready        screen_x/y/z, inv_w, near_clipped, range_fault
//  cfg       in   cfg_we_i, no wait  cfg_idx_i selects matrix register, cfg_data_i
//
//  Throughput: one vertex per clock unless a stall below holds; every stage is fully pipelined.
//  Path: registered transform, then the queue, then the back end, whose depth is
//  set by two chained dividers (one quotient bit per stage).
//  Reset clears handshake and queue state and loads the identity matrix.
//  Front stalls only when the queue is full; back stalls only when res_o holds
//  an untaken transfer.
module vertex_transform_near_clip (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  vtnc_in_if.sink                           vtx_i,
  vtnc_out_if.source                        res_o,
  input  logic                              cfg_we_i,
  input  logic [vtnc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vtnc_pkg::CFG_W-1:0]        cfg_data_i
);
  import vtnc_pkg::*;

  cfg_regs_t  cfg_q;
  clip_item_t push_item, pop_item;
  logic       push, pop, full, empty;

  // matrix registers, to be written only while idle; the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // front: transform and classify
  vtnc_front u_front (
    .clk_i, .rst_ni, .vtx_i, .cfg_i(cfg_q), .full_i(full), .push_o(push),
    .item_o(push_item)
  );

  // short queue decouples front and back stalls
  vtnc_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_item), .full_o(full),
    .pop_i(pop), .data_o(pop_item), .empty_o(empty)
  );

  // back: near-plane rule and perspective divide
  vtnc_back u_back (
    .clk_i, .rst_ni, .data_i(pop_item), .empty_i(empty), .pop_o(pop), .res_o
  );

  // near rule forces z = w = 0.1, so z/w is exactly one and 1/w is fixed
  a_near_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.near_clipped |->
      res_o.screen_z == Q_ONE && res_o.inv_w == 32'sd655320)
    else $error("near-clipped result has wrong z or 1/w");

  // 1/w can only reach the positive limit through saturation
  a_invw_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.inv_w == S32_MAX |-> res_o.range_fault)
    else $error("saturated 1/w without range_fault");

endmodule

/* tb/sv/vertex_transform_near_clip_test.sv */
module vertex_transform_near_clip_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vtnc_pkg::*;

  // Drain time after the last result; generous against the back-end depth.
  localparam int DRAIN_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] iw;
    logic               clipped;
    logic               fault;
  } screen_vtx_t;

  typedef struct {
    logic signed [31:0] x, y, z, w;
    bit                 typed;   // expected result given in the row
    screen_vtx_t        res;
  } vtx_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  vtnc_in_if vtx_if ();
  vtnc_out_if res_if ();

  vertex_transform_near_clip dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .vtx_i(vtx_if.sink), .res_o(res_if.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Local copy of the matrix registers.
  logic [CFG_W-1:0] matrix_q [CFG_NUM];

  screen_vtx_t screen_queue [$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;

  // ---------------- predictor ----------------
  function automatic logic signed [127:0] floor_q16(input logic signed [127:0] v);
    return v >>> 16;  // arithmetic shift is floor
  endfunction

  function automatic logic signed [127:0] clamp32(input logic signed [127:0] v,
                                                  inout bit flag);
    if (v > 128'sd2147483647) begin
      flag = 1'b1;
      return 128'sd2147483647;
    end
    if (v < -128'sd2147483648) begin
      flag = 1'b1;
      return -128'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [127:0] mcoef(input int row, input int col);
    logic [63:0] r;
    r = matrix_q[row*2 + col/2];
    return (col % 2) ? 128'(signed'(r[63:32])) : 128'(signed'(r[31:0]));
  endfunction

  function automatic logic signed [127:0] qdivide(input logic signed [127:0] a,
                                                  input logic signed [127:0] d,
                                                  inout bit flag);
    if (d == 0) begin
      flag = 1'b1;
      return (a < 0) ? -128'sd2147483648 : 128'sd2147483647;
    end
    return clamp32((a * 65536) / d, flag);  // SV division truncates toward zero
  endfunction

  function automatic screen_vtx_t project_vertex(input logic signed [31:0] px, py, pz, pw);
    logic signed [127:0] v [3];
    logic signed [127:0] clip [4];
    logic signed [127:0] num, den, t;
    bit fault, clipped;
    screen_vtx_t r;
    fault = 1'b0;
    clipped = 1'b0;
    v[0] = px; v[1] = py; v[2] = pz;
    // exact sum, floored once
    for (int c = 0; c < 4; c++) begin
      clip[c] = mcoef(3, c) * 65536;
      for (int k = 0; k < 3; k++) clip[c] += mcoef(k, c) * v[k];
      clip[c] = clamp32(floor_q16(clip[c]), fault);
    end
    if (clip[3] < 0) begin
      clipped = 1'b1;
      num = 128'(Q_NEAR) - 128'(pw);
      den = clip[3] - 128'(pw);
      if (den == 0) begin
        fault = 1'b1;
        t = (num >= 0) ? 128'sd2147483647 : -128'sd2147483648;
      end else begin
        t = clamp32((num * 65536) / den, fault);
      end
      clip[0] = clamp32(v[0] + floor_q16(t * (clip[0] - v[0])), fault);
      clip[1] = clamp32(v[1] + floor_q16(t * (clip[1] - v[1])), fault);
      clip[2] = Q_NEAR;
      clip[3] = Q_NEAR;
    end
    r.sx = 32'(qdivide(clip[0], clip[3], fault));
    r.sy = 32'(qdivide(clip[1], clip[3], fault));
    r.sz = 32'(qdivide(clip[2], clip[3], fault));
    r.iw = 32'(qdivide(128'(Q_ONE), clip[3], fault));
    r.clipped = clipped;
    r.fault = fault;
    return r;
  endfunction

  // ---------------- driving ----------------
  task automatic write_matrix(input int idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[CFG_IDX_W-1:0];
    cfg_data_i <= val;
    matrix_q[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One transfer on the vertex channel; optional gap before it.
  // valid stays up after the transfer until a gap or the drain drops it.
  task automatic send_vertex(input logic signed [31:0] px, py, pz, pw,
                             input bit typed, input screen_vtx_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      vtx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    vtx_if.valid <= 1'b1;
    vtx_if.pos_x <= px;
    vtx_if.pos_y <= py;
    vtx_if.pos_z <= pz;
    vtx_if.pos_w <= pw;
    do @(posedge clk_i); while (!vtx_if.ready);
    screen_queue.push_back(typed ? typed_res : project_vertex(px, py, pz, pw));
    @(negedge clk_i);
  endtask

  // Wait until every expected result is back, plus DRAIN_CYCLES of drain time.
  task automatic drain_pipe();
    vtx_if.valid <= 1'b0;
    while (screen_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
      default: return $signed($urandom_range(0, 32'h0000_ffff)) - 32'sh0000_8000;
    endcase
  endfunction

  function automatic logic [63:0] rand_coef_pair(input int mode);
    logic [31:0] a, b;
    a = rand_coord(mode);
    b = rand_coord(mode);
    return {b, a};
  endfunction

  // ---------------- receiving and checking ----------------
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    screen_vtx_t exp_r;
    if (rst_ni) begin
      if ((vtx_if.valid && vtx_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (res_if.valid && res_if.ready) begin
        if (screen_queue.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          exp_r = screen_queue.pop_front();
          if (res_if.screen_x !== exp_r.sx) begin
            $error("screen_x exp %0d got %0d", exp_r.sx, res_if.screen_x); errors++;
          end
          if (res_if.screen_y !== exp_r.sy) begin
            $error("screen_y exp %0d got %0d", exp_r.sy, res_if.screen_y); errors++;
          end
          if (res_if.screen_z !== exp_r.sz) begin
            $error("screen_z exp %0d got %0d", exp_r.sz, res_if.screen_z); errors++;
          end
          if (res_if.inv_w !== exp_r.iw) begin
            $error("inv_w exp %0d got %0d", exp_r.iw, res_if.inv_w); errors++;
          end
          if (res_if.near_clipped !== exp_r.clipped) begin
            $error("near_clipped exp %0b got %0b", exp_r.clipped, res_if.near_clipped);
            errors++;
          end
          if (res_if.range_fault !== exp_r.fault) begin
            $error("range_fault exp %0b got %0b", exp_r.fault, res_if.range_fault);
            errors++;
          end
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("vertex_transform_near_clip: mismatch");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  vtx_row_t dir_rows [$];

  function automatic vtx_row_t mk_row(input logic signed [31:0] x, y, z, w,
                                      input bit typed, input screen_vtx_t res);
    vtx_row_t r;
    r.x = x; r.y = y; r.z = z; r.w = w; r.typed = typed; r.res = res;
    return r;
  endfunction

  initial begin
    screen_vtx_t none;
    logic signed [31:0] px, py, pz, pw;
    int mode;
    none = '0;
    vtx_if.valid = 1'b0;
    vtx_if.pos_x = '0;
    vtx_if.pos_y = '0;
    vtx_if.pos_z = '0;
    vtx_if.pos_w = '0;
    res_if.ready = 1'b0;
    for (int i = 0; i < CFG_NUM; i++) matrix_q[i] = CFG_RESET[i];

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table. Identity matrix: clip w = 1.0, so screen = input,
    // inv_w = 1.0; typed where obvious.
    dir_rows.push_back(mk_row(0, 0, 0, 0, 1, '{0, 0, 0, 65536, 0, 0}));
    dir_rows.push_back(mk_row(65536, -65536, 131072, 0, 1,
                              '{65536, -65536, 131072, 65536, 0, 0}));
    dir_rows.push_back(mk_row(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1,
                              '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 65536, 0, 0}));
    dir_rows.push_back(mk_row(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1,
                              '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 65536, 0, 0}));
    dir_rows.push_back(mk_row(-1, -1, -1, -1, 0, none));
    foreach (dir_rows[i])
      send_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].w,
                  dir_rows[i].typed, dir_rows[i].res);
    drain_pipe();

    // Zero translation on w: clip w = 0 -> zero divisor.
    write_matrix(7, 64'h0);
    send_vertex(65536, -65536, 0, 0, 1, '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                          32'sh7fffffff, 0, 1});
    send_vertex(3, 4, 5, 6, 0, none);
    drain_pipe();
    // w = -1.0: near rule, incl. zero near denominator (pos_w == clip w).
    write_matrix(7, 64'hffff_0000_0000_0000);
    send_vertex(65536, 65536, 65536, -65536, 0, none);
    send_vertex(65536, 65536, 65536, 6554, 0, none);
    send_vertex(32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 0, none);
    send_vertex(100, 200, 300, 32'sh7fffffff, 0, none);
    drain_pipe();
    // w row taken from z: z large positive or negative.
    write_matrix(5, 64'h0001_0000_0001_0000);
    send_vertex(1000, -1000, 32'sh7fffffff, 0, 0, none);
    send_vertex(1000, -1000, 32'sh80000000, 12345, 0, none);
    send_vertex(5, 5, -65536, 65536, 0, none);
    drain_pipe();
    // Extreme coefficients everywhere: overflow saturation.
    for (int i = 0; i < CFG_NUM; i++) write_matrix(i, 64'h7fff_ffff_7fff_ffff);
    send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, none);
    send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, none);
    drain_pipe();
    for (int i = 0; i < CFG_NUM; i++) write_matrix(i, 64'h8000_0000_8000_0000);
    send_vertex(32'sh7fffffff, 32'sh80000000, 1, -1, 0, none);
    send_vertex(65536, 65536, 65536, 65536, 0, none);
    drain_pipe();

    // Random phases: each phase new matrix and new idling mix.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      mode = ph % 3;
      for (int i = 0; i < CFG_NUM; i++) write_matrix(i, rand_coef_pair(mode));
      if (ph == 11) for (int i = 0; i < CFG_NUM; i++) write_matrix(i, CFG_RESET[i]);
      for (int n = 0; n < 112; n++) begin
        px = rand_coord($urandom_range(2));
        py = rand_coord($urandom_range(2));
        pz = rand_coord($urandom_range(2));
        pw = rand_coord($urandom_range(2));
        send_vertex(px, py, pz, pw, 0, none);
      end
      drain_pipe();
    end

    if (errors == 0 && screen_queue.size() == 0) begin
      $display("vertex_transform_near_clip: match");
    end else begin
      $display("vertex_transform_near_clip: mismatch");
    end
    $finish;
  end

endmodule
